// File: rtl/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types, codes and helpers for the brainfuck core.
// ----------------------------------------------------------------------------
package bfc_pkg;

  // default storage sizes
  localparam int PROG_DEPTH_DEF = 4096;
  localparam int DATA_DEPTH_DEF = 4096;

  // fixed field widths
  localparam int CELL_W   = 64;
  localparam int BYTE_W   = 8;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;
  localparam int SIZE_W   = 2;
  localparam int CELLS_W  = 13;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STEP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_NORMAL = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXIT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BRANCH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

  // instruction bytes
  localparam logic [BYTE_W-1:0] OP_INC   = 8'h2B;
  localparam logic [BYTE_W-1:0] OP_DEC   = 8'h2D;
  localparam logic [BYTE_W-1:0] OP_LEFT  = 8'h3C;
  localparam logic [BYTE_W-1:0] OP_RIGHT = 8'h3E;
  localparam logic [BYTE_W-1:0] OP_IN    = 8'h2C;
  localparam logic [BYTE_W-1:0] OP_OUT   = 8'h2E;
  localparam logic [BYTE_W-1:0] OP_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] OP_CLOSE = 8'h5D;

  // register indexes
  localparam logic CFG_IDX_SIZE  = 1'b0;
  localparam logic CFG_IDX_CELLS = 1'b1;

  // cell width codes
  localparam logic [SIZE_W-1:0] SIZE_8  = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_16 = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_32 = 2'd2;
  localparam logic [SIZE_W-1:0] SIZE_64 = 2'd3;

  // which result the datapath loads
  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_END,
    RES_FULL,
    RES_STEP
  } res_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     clr_start;
    logic     clr_wr;
    logic     load;
    logic     pop_w1;
    logic     pop_w2;
    logic     cap;
    logic     jmp_rd;
    logic     exec;
    logic     emit;
    res_sel_t res_sel;
  } bfc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;
    logic at_end;
    logic pop_pending;
    logic clr_last;
    logic need_jump;
  } bfc_sts_t;

  function automatic logic [CELL_W-1:0] width_mask(input logic [SIZE_W-1:0] code);
    logic [CELL_W-1:0] m;
    case (code)
      SIZE_8:  m = 64'h0000_0000_0000_00ff;
      SIZE_16: m = 64'h0000_0000_0000_ffff;
      SIZE_32: m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic is_op(input logic [BYTE_W-1:0] b);
    return (b == OP_INC) || (b == OP_DEC) || (b == OP_LEFT) || (b == OP_RIGHT) ||
           (b == OP_IN) || (b == OP_OUT) || (b == OP_OPEN) || (b == OP_CLOSE);
  endfunction

endpackage

// File: rtl/bfc_ram.sv
// ----------------------------------------------------------------------------
// bfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bfc_regs.sv
// ----------------------------------------------------------------------------
// bfc_regs
// APB register file: cell width code and number of data cells in use.
// ----------------------------------------------------------------------------
module bfc_regs
  import bfc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  output logic [SIZE_W-1:0]   cell_size_code,
  output logic [CELLS_W-1:0]  data_cells
);

  logic [SIZE_W-1:0]  size_r;
  logic [CELLS_W-1:0] cells_r;
  logic               wr_en;
  logic               idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= SIZE_8;
      cells_r <= CELLS_W'(DATA_DEPTH_DEF);
    end else if (wr_en) begin
      unique case (idx)
        CFG_IDX_SIZE:  size_r  <= pwdata[SIZE_W-1:0];
        CFG_IDX_CELLS: cells_r <= pwdata[CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      CFG_IDX_SIZE:  prdata = APB_DW'(size_r);
      CFG_IDX_CELLS: prdata = APB_DW'(cells_r);
      default:       prdata = '0;
    endcase
  end

  assign pready         = 1'b1;
  assign cell_size_code = size_r;
  assign data_cells     = cells_r;

endmodule

// File: rtl/bfc_ctrl.sv
// ----------------------------------------------------------------------------
// bfc_ctrl
// Controller: sequences load, step and clear transactions for the datapath.
// ----------------------------------------------------------------------------
module bfc_ctrl
  import bfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [REQ_W-1:0] req_type,
  input  bfc_sts_t         sts,
  output logic             busy,
  output bfc_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_POP1,
    S_POP2,
    S_SRD,
    S_SEV,
    S_SJMP
  } state_t;

  state_t state_r, state_nxt;
  logic   clr_emit_r, clr_emit_nxt;

  assign busy = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    clr_emit_nxt = clr_emit_r;
    cmd          = '0;
    cmd.res_sel  = RES_PLAIN;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt    = S_IDLE;
          cmd.emit     = clr_emit_r;
          clr_emit_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (req_type)
            REQ_LOAD: begin
              if (sts.full) begin
                cmd.emit    = 1'b1;
                cmd.res_sel = RES_FULL;
              end else begin
                cmd.load = 1'b1;
                if (sts.pop_pending) begin
                  state_nxt = S_POP1;
                end else begin
                  cmd.emit = 1'b1;
                end
              end
            end
            REQ_STEP: begin
              if (sts.at_end) begin
                cmd.emit    = 1'b1;
                cmd.res_sel = RES_END;
              end else begin
                cmd.cap   = 1'b1;
                state_nxt = S_SRD;
              end
            end
            REQ_CLEAR: begin
              cmd.clr_start = 1'b1;
              clr_emit_nxt  = 1'b1;
              state_nxt     = S_CLEAR;
            end
            default: begin
              cmd.emit = 1'b1;
            end
          endcase
        end
      end
      S_POP1: begin
        cmd.pop_w1 = 1'b1;
        state_nxt  = S_POP2;
      end
      S_POP2: begin
        cmd.pop_w2 = 1'b1;
        cmd.emit   = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SRD: begin
        state_nxt = S_SEV;
      end
      S_SEV: begin
        cmd.jmp_rd = 1'b1;
        if (sts.need_jump) begin
          state_nxt = S_SJMP;
        end else begin
          cmd.exec    = 1'b1;
          cmd.emit    = 1'b1;
          cmd.res_sel = RES_STEP;
          state_nxt   = S_IDLE;
        end
      end
      S_SJMP: begin
        cmd.exec    = 1'b1;
        cmd.emit    = 1'b1;
        cmd.res_sel = RES_STEP;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register; reset starts a clearing pass with no result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_emit_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_emit_r <= clr_emit_nxt;
    end
  end

endmodule

// File: rtl/bfc_dpath.sv
// ----------------------------------------------------------------------------
// bfc_dpath
// Datapath: program, link, partner, bracket stack and cell memories, the
// pointers and the instruction evaluator.
// ----------------------------------------------------------------------------
module bfc_dpath
  import bfc_pkg::*;
#(
  parameter int PROG_DEPTH = PROG_DEPTH_DEF,
  parameter int DATA_DEPTH = DATA_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bfc_cmd_t            cmd,
  output bfc_sts_t            sts,
  input  logic [BYTE_W-1:0]   program_byte,
  input  logic [BYTE_W-1:0]   in_byte,
  input  logic                in_eof,
  input  logic [SIZE_W-1:0]   cell_size_code,
  input  logic [CELLS_W-1:0]  data_cells,
  output logic                res_strobe,
  output logic [STATUS_W-1:0] res_status,
  output logic                res_out_valid,
  output logic [BYTE_W-1:0]   res_out_char,
  output logic                res_in_taken,
  output logic [$clog2(PROG_DEPTH+1)-1:0] res_pc_now,
  output logic [((DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1)-1:0] res_cell_index
);

  localparam int LW    = $clog2(PROG_DEPTH + 1);
  localparam int AW    = $clog2(PROG_DEPTH);
  localparam int DW    = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int MAXD  = (PROG_DEPTH > DATA_DEPTH) ? PROG_DEPTH : DATA_DEPTH;
  localparam int CNTW  = $clog2(MAXD);
  localparam int DDW   = $clog2(DATA_DEPTH + 1);
  localparam int LIMW  = (DDW > CELLS_W) ? DDW : CELLS_W;

  // pointers and counters
  logic [LW-1:0]   length_r;
  logic [LW-1:0]   open_cnt_r;
  logic [AW-1:0]   anchor_r;
  logic [LW-1:0]   pc_r;
  logic [DW-1:0]   dp_r;
  logic [CNTW-1:0] clr_cnt_r;
  logic            strobe_r;

  // payload registers
  logic [AW-1:0]     ld_n_r;
  logic [AW-1:0]     ld_o_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_eof_r;

  // memory ports
  logic [BYTE_W-1:0] prog_rd;
  logic              prog_we;
  logic [AW:0]       link_rd, link_wd;
  logic              link_we;
  logic [AW-1:0]     link_wa, link_ra;
  logic [AW:0]       part_rd, part_wd;
  logic              part_we;
  logic [AW-1:0]     part_wa;
  logic [AW-1:0]     stk_rd;
  logic              stk_we;
  logic [LW-1:0]     stk_top;
  logic [CELL_W-1:0] cell_rd, cell_wd;
  logic              cell_we;
  logic [DW-1:0]     cell_wa;

  // load decode
  logic [AW-1:0] ld_n;
  logic          ld_push, ld_pop, ld_link;
  logic          clr_prog, clr_data, clr_last;

  // evaluator
  logic [CELL_W-1:0]   mask, cur;
  logic [LIMW-1:0]     limit, cells_ext, dp_ext, dp_inc;
  logic                dp_ok, zero, jump, cellop;
  logic [LW-1:0]       follow_val;
  logic [STATUS_W-1:0] ev_status;
  logic                ev_pc_upd, ev_dp_upd, ev_cell_we, ev_valid, ev_taken, ev_jump;
  logic [DW-1:0]       ev_dp_nxt;
  logic [CELL_W-1:0]   ev_cell_wd;
  logic [BYTE_W-1:0]   ev_char;

  // result next values
  logic [STATUS_W-1:0] st_nxt;
  logic [LW-1:0]       pc_now_nxt;
  logic [DW-1:0]       dp_now_nxt;

  // load side decode
  assign ld_n    = length_r[AW-1:0];
  assign ld_push = cmd.load && (program_byte == OP_OPEN);
  assign ld_pop  = cmd.load && (program_byte == OP_CLOSE) && (open_cnt_r != '0);
  assign ld_link = cmd.load && is_op(program_byte) && (ld_n != '0);
  assign stk_top = open_cnt_r - LW'(1);

  // clearing pass decode
  assign clr_prog = cmd.clr_wr && ({1'b0, clr_cnt_r} < (CNTW+1)'(PROG_DEPTH));
  assign clr_data = cmd.clr_wr && ({1'b0, clr_cnt_r} < (CNTW+1)'(DATA_DEPTH));
  assign clr_last = (clr_cnt_r == CNTW'(MAXD - 1));

  // status to controller
  assign sts.full        = (length_r == LW'(PROG_DEPTH));
  assign sts.at_end      = (pc_r >= length_r);
  assign sts.pop_pending = (program_byte == OP_CLOSE) && (open_cnt_r != '0);
  assign sts.clr_last    = clr_last;
  assign sts.need_jump   = ev_jump;

  // program store
  assign prog_we = cmd.load;
  bfc_ram #(.WIDTH(BYTE_W), .DEPTH(PROG_DEPTH)) u_prog (
    .clk(clk), .we(prog_we), .waddr(ld_n), .wdata(program_byte),
    .raddr(pc_r[AW-1:0]), .rdata(prog_rd)
  );

  // open-bracket stack
  assign stk_we = ld_push;
  bfc_ram #(.WIDTH(AW), .DEPTH(PROG_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(open_cnt_r[AW-1:0]), .wdata(ld_n),
    .raddr(stk_top[AW-1:0]), .rdata(stk_rd)
  );

  // next-instruction links, valid bit on top
  always_comb begin
    link_we = 1'b0;
    link_wa = anchor_r;
    link_wd = {1'b1, ld_n};
    if (clr_prog) begin
      link_we = 1'b1;
      link_wa = clr_cnt_r[AW-1:0];
      link_wd = '0;
    end else if (ld_link) begin
      link_we = 1'b1;
    end
  end
  assign link_ra = cmd.jmp_rd ? part_rd[AW-1:0] : pc_r[AW-1:0];

  bfc_ram #(.WIDTH(AW+1), .DEPTH(PROG_DEPTH)) u_link (
    .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
    .raddr(link_ra), .rdata(link_rd)
  );

  // bracket partners, valid bit on top
  always_comb begin
    part_we = 1'b0;
    part_wa = ld_n_r;
    part_wd = {1'b1, stk_rd};
    if (clr_prog) begin
      part_we = 1'b1;
      part_wa = clr_cnt_r[AW-1:0];
      part_wd = '0;
    end else if (cmd.pop_w1) begin
      part_we = 1'b1;
    end else if (cmd.pop_w2) begin
      part_we = 1'b1;
      part_wa = ld_o_r;
      part_wd = {1'b1, ld_n_r};
    end
  end

  bfc_ram #(.WIDTH(AW+1), .DEPTH(PROG_DEPTH)) u_part (
    .clk(clk), .we(part_we), .waddr(part_wa), .wdata(part_wd),
    .raddr(pc_r[AW-1:0]), .rdata(part_rd)
  );

  // data cells
  always_comb begin
    cell_we = 1'b0;
    cell_wa = dp_r;
    cell_wd = ev_cell_wd;
    if (clr_data) begin
      cell_we = 1'b1;
      cell_wa = clr_cnt_r[DW-1:0];
      cell_wd = '0;
    end else if (cmd.exec && ev_cell_we) begin
      cell_we = 1'b1;
    end
  end

  bfc_ram #(.WIDTH(CELL_W), .DEPTH(DATA_DEPTH)) u_cell (
    .clk(clk), .we(cell_we), .waddr(cell_wa), .wdata(cell_wd),
    .raddr(dp_r), .rdata(cell_rd)
  );

  // operand preparation
  assign mask       = width_mask(cell_size_code);
  assign cur        = cell_rd & mask;
  assign cells_ext  = LIMW'(data_cells);
  assign limit      = (cells_ext > LIMW'(DATA_DEPTH)) ? LIMW'(DATA_DEPTH) : cells_ext;
  assign dp_ext     = LIMW'(dp_r);
  assign dp_inc     = dp_ext + LIMW'(1);
  assign dp_ok      = (dp_ext < limit);
  assign zero       = (cur == '0);
  assign jump       = ((prog_rd == OP_OPEN) == zero);
  assign follow_val = link_rd[AW] ? LW'(link_rd[AW-1:0]) : length_r;
  assign cellop     = (prog_rd == OP_INC) || (prog_rd == OP_DEC) || (prog_rd == OP_IN) ||
                      (prog_rd == OP_OUT) || (prog_rd == OP_OPEN) || (prog_rd == OP_CLOSE);

  // instruction evaluator
  always_comb begin
    ev_status  = ST_NORMAL;
    ev_pc_upd  = 1'b0;
    ev_dp_upd  = 1'b0;
    ev_dp_nxt  = dp_r;
    ev_cell_we = 1'b0;
    ev_cell_wd = '0;
    ev_valid   = 1'b0;
    ev_char    = '0;
    ev_taken   = 1'b0;
    ev_jump    = 1'b0;
    if (cellop && !dp_ok) begin
      ev_status = ST_RANGE;
    end else begin
      unique case (prog_rd) inside
        OP_INC: begin
          ev_cell_we = 1'b1;
          ev_cell_wd = (cell_rd + CELL_W'(1)) & mask;
        end
        OP_DEC: begin
          ev_cell_we = 1'b1;
          ev_cell_wd = (cell_rd - CELL_W'(1)) & mask;
        end
        OP_LEFT: begin
          if (dp_r == '0) begin
            ev_status = ST_RANGE;
          end else begin
            ev_dp_upd = 1'b1;
            ev_dp_nxt = dp_r - DW'(1);
          end
        end
        OP_RIGHT: begin
          if (dp_inc >= limit) begin
            ev_status = ST_RANGE;
          end else begin
            ev_dp_upd = 1'b1;
            ev_dp_nxt = dp_inc[DW-1:0];
          end
        end
        OP_IN: begin
          ev_cell_we = 1'b1;
          ev_cell_wd = (in_eof_r ? '1 : CELL_W'(in_byte_r)) & mask;
          ev_taken   = 1'b1;
        end
        OP_OUT: begin
          ev_valid = 1'b1;
          ev_char  = cur[BYTE_W-1:0];
        end
        OP_OPEN, OP_CLOSE: begin
          if (jump) begin
            if (!part_rd[AW]) begin
              ev_status = ST_BRANCH;
            end else begin
              ev_jump = 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (ev_status == ST_NORMAL) begin
        ev_pc_upd = 1'b1;
        ev_status = (follow_val < length_r) ? ST_NORMAL : ST_EXIT;
      end
    end
  end

  // result selection
  always_comb begin
    unique case (cmd.res_sel)
      RES_STEP: st_nxt = ev_status;
      RES_END:  st_nxt = ST_EXIT;
      RES_FULL: st_nxt = ST_FULL;
      default:  st_nxt = ST_NORMAL;
    endcase
    pc_now_nxt = ((cmd.res_sel == RES_STEP) && ev_pc_upd) ? follow_val : pc_r;
    dp_now_nxt = ((cmd.res_sel == RES_STEP) && ev_dp_upd) ? ev_dp_nxt : dp_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r   <= '0;
      open_cnt_r <= '0;
      anchor_r   <= '0;
      pc_r       <= '0;
      dp_r       <= '0;
      clr_cnt_r  <= '0;
      strobe_r   <= 1'b0;
    end else begin
      strobe_r <= cmd.emit;
      if (cmd.clr_start) begin
        length_r   <= '0;
        open_cnt_r <= '0;
        anchor_r   <= '0;
        pc_r       <= '0;
        dp_r       <= '0;
        clr_cnt_r  <= '0;
      end else if (cmd.clr_wr && !clr_last) begin
        clr_cnt_r <= clr_cnt_r + CNTW'(1);
      end
      if (cmd.load) begin
        length_r <= length_r + LW'(1);
        if (ld_push) begin
          open_cnt_r <= open_cnt_r + LW'(1);
        end else if (ld_pop) begin
          open_cnt_r <= stk_top;
        end
        if (ld_link) begin
          anchor_r <= ld_n;
        end
      end
      if (cmd.exec) begin
        if (ev_pc_upd) begin
          pc_r <= follow_val;
        end
        if (ev_dp_upd) begin
          dp_r <= ev_dp_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ld_n_r <= ld_n;
    end
    if (cmd.pop_w1) begin
      ld_o_r <= stk_rd;
    end
    if (cmd.cap) begin
      in_byte_r <= in_byte;
      in_eof_r  <= in_eof;
    end
    if (cmd.emit) begin
      res_status     <= st_nxt;
      res_out_valid  <= (cmd.res_sel == RES_STEP) && ev_valid;
      res_out_char   <= (cmd.res_sel == RES_STEP) ? ev_char : '0;
      res_in_taken   <= (cmd.res_sel == RES_STEP) && ev_taken;
      res_pc_now     <= pc_now_nxt;
      res_cell_index <= dp_now_nxt;
    end
  end

  assign res_strobe = strobe_r;

endmodule

// File: rtl/brainfuck_core.sv
// ----------------------------------------------------------------------------
// brainfuck_core
// Brainfuck core: loads program bytes, runs one instruction per step item
// and clears program and data on request.
// ----------------------------------------------------------------------------
//  channel   handshake                       payload
//  input     start, busy (accept: start&!busy) in_req_type, in_program_byte,
//                                            in_in_byte, in_in_eof
//  result    out_strobe (one cycle)          out_status, out_out_valid,
//                                            out_out_char, out_in_taken,
//                                            out_pc_now, out_cell_index
//  config    APB psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// load: result in the cycle after accept; a ']' closing a bracket goes via
// S_POP1, S_POP2 (stack read, then one partner write per bracket on the single
// write port). step: S_SRD, S_SEV (program/link/partner/cell reads, evaluate,
// write back), plus S_SJMP when a bracket jumps (one more dependent link read
// at the partner). clear: a pass over max(PROG_DEPTH, DATA_DEPTH) entries, one
// per cycle, also after reset with busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
module brainfuck_core
  import bfc_pkg::*;
#(
  parameter int PROG_DEPTH = PROG_DEPTH_DEF,
  parameter int DATA_DEPTH = DATA_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [BYTE_W-1:0]   in_program_byte,
  input  logic [BYTE_W-1:0]   in_in_byte,
  input  logic                in_in_eof,
  output logic                out_strobe,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_out_valid,
  output logic [BYTE_W-1:0]   out_out_char,
  output logic                out_in_taken,
  output logic [$clog2(PROG_DEPTH+1)-1:0] out_pc_now,
  output logic [((DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1)-1:0] out_cell_index,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  bfc_cmd_t           cmd;
  bfc_sts_t           sts;
  logic [SIZE_W-1:0]  cell_size_code;
  logic [CELLS_W-1:0] data_cells;

  // configuration registers
  bfc_regs u_regs (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cell_size_code(cell_size_code), .data_cells(data_cells)
  );

  // sequencing
  bfc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .req_type(in_req_type),
    .sts(sts), .busy(busy), .cmd(cmd)
  );

  // storage and evaluation
  bfc_dpath #(.PROG_DEPTH(PROG_DEPTH), .DATA_DEPTH(DATA_DEPTH)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .program_byte(in_program_byte), .in_byte(in_in_byte), .in_eof(in_in_eof),
    .cell_size_code(cell_size_code), .data_cells(data_cells),
    .res_strobe(out_strobe), .res_status(out_status),
    .res_out_valid(out_out_valid), .res_out_char(out_out_char),
    .res_in_taken(out_in_taken), .res_pc_now(out_pc_now),
    .res_cell_index(out_cell_index)
  );

`ifndef NO_ASSERTIONS
  // a load of any byte other than ']' answers in the next cycle
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req_type == REQ_LOAD) && (in_program_byte != OP_CLOSE)
    |=> out_strobe)
    else $error("load transaction gave no result in the next cycle");

  // an unknown request answers at once with normal status
  a_none_fast: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req_type == REQ_NONE)
    |=> out_strobe && (out_status == ST_NORMAL))
    else $error("unknown request not answered with normal status");

  // output and input consumption only come from a successful step
  a_io_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_out_valid || out_in_taken)
    |-> !(out_out_valid && out_in_taken) &&
        ((out_status == ST_NORMAL) || (out_status == ST_EXIT)))
    else $error("i/o flags on a failed or mixed step");
`endif

endmodule

// File: tb/brainfuck_core_test.sv
// ----------------------------------------------------------------------------
// brainfuck_core_test
// Self-checking bench for the brainfuck core: loads programs, steps them and
// clears, under a range of cell widths and cell counts. A predictor in the
// bench tracks program, bracket, link and data state and checks every result
// transaction field by field against it.
// ----------------------------------------------------------------------------
module brainfuck_core_test;
  import bfc_pkg::*;

  localparam int PDEPTH = 4096;
  localparam int DDEPTH = 4096;
  localparam int LIMIT_CYCLES = 20000000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                ovalid;
    logic [BYTE_W-1:0]   ochar;
    logic                taken;
    logic [12:0]         pc;
    logic [11:0]         cidx;
  } bf_res_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [REQ_W-1:0] in_req_type;
  logic [BYTE_W-1:0] in_program_byte;
  logic [BYTE_W-1:0] in_in_byte;
  logic in_in_eof;
  logic out_strobe;
  logic [STATUS_W-1:0] out_status;
  logic out_out_valid;
  logic [BYTE_W-1:0] out_out_char;
  logic out_in_taken;
  logic [12:0] out_pc_now;
  logic [11:0] out_cell_index;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  brainfuck_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_program_byte(in_program_byte),
    .in_in_byte(in_in_byte), .in_in_eof(in_in_eof),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_out_valid(out_out_valid), .out_out_char(out_out_char),
    .out_in_taken(out_in_taken), .out_pc_now(out_pc_now),
    .out_cell_index(out_cell_index),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // predicted core state
  logic [7:0]  prog_mem [PDEPTH];
  logic [12:0] link_to [PDEPTH];
  logic        link_ok [PDEPTH];
  logic [12:0] partner [PDEPTH];
  logic        partner_ok [PDEPTH];
  logic [11:0] open_pos [PDEPTH];
  logic [63:0] cell_mem [DDEPTH];
  int unsigned prog_len, open_cnt, anchor, pc_reg, dp_reg;
  logic [SIZE_W-1:0] width_code;
  int unsigned cells_used;

  bf_res_t expected_results[$];
  int fails;
  int gap_pct;
  int unsigned cycles;

  function automatic bit is_instr(input logic [7:0] b);
    case (b)
      OP_INC, OP_DEC, OP_LEFT, OP_RIGHT, OP_IN, OP_OUT, OP_OPEN, OP_CLOSE: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic int unsigned next_of(input int unsigned pos);
    if (pos < PDEPTH && link_ok[pos]) return 32'(link_to[pos]);
    return prog_len;
  endfunction

  function automatic void wipe_core();
    for (int i = 0; i < PDEPTH; i++) begin
      link_ok[i] = 1'b0;
      partner_ok[i] = 1'b0;
    end
    for (int i = 0; i < DDEPTH; i++) cell_mem[i] = '0;
    prog_len = 0;
    open_cnt = 0;
    anchor = 0;
    pc_reg = 0;
    dp_reg = 0;
  endfunction

  function automatic logic [STATUS_W-1:0] append_byte(input logic [7:0] b);
    int unsigned n;
    int unsigned o;
    n = prog_len;
    if (n >= PDEPTH) return ST_FULL;
    prog_mem[n] = b;
    if (b == OP_OPEN) begin
      open_pos[open_cnt] = n[11:0];
      open_cnt++;
    end else if (b == OP_CLOSE && open_cnt > 0) begin
      open_cnt--;
      o = 32'(open_pos[open_cnt]);
      partner[n] = o[12:0];
      partner_ok[n] = 1'b1;
      partner[o] = n[12:0];
      partner_ok[o] = 1'b1;
    end
    if (is_instr(b) && n > 0) begin
      link_to[anchor] = n[12:0];
      link_ok[anchor] = 1'b1;
      anchor = n;
    end
    prog_len = n + 1;
    return ST_NORMAL;
  endfunction

  function automatic logic [STATUS_W-1:0] run_instr(input logic [7:0] ib, input logic eof,
                                                   inout bf_res_t r);
    int unsigned lim, nxt;
    logic [63:0] m;
    logic [7:0] op;
    bit zero;
    lim = (cells_used > DDEPTH) ? DDEPTH : cells_used;
    case (width_code)
      SIZE_8:  m = 64'hff;
      SIZE_16: m = 64'hffff;
      SIZE_32: m = 64'hffff_ffff;
      default: m = '1;
    endcase
    if (pc_reg >= prog_len || pc_reg >= PDEPTH) return ST_EXIT;
    nxt = next_of(pc_reg);
    op = prog_mem[pc_reg];
    if (op inside {OP_INC, OP_DEC, OP_IN, OP_OUT, OP_OPEN, OP_CLOSE} && dp_reg >= lim)
      return ST_RANGE;
    case (op)
      OP_INC: cell_mem[dp_reg] = (cell_mem[dp_reg] + 64'd1) & m;
      OP_DEC: cell_mem[dp_reg] = (cell_mem[dp_reg] - 64'd1) & m;
      OP_LEFT: begin
        if (dp_reg == 0) return ST_RANGE;
        dp_reg--;
      end
      OP_RIGHT: begin
        if (dp_reg + 1 >= lim) return ST_RANGE;
        dp_reg++;
      end
      OP_IN: begin
        cell_mem[dp_reg] = (eof ? 64'hffff_ffff_ffff_ffff : {56'd0, ib}) & m;
        r.taken = 1'b1;
      end
      OP_OUT: begin
        r.ovalid = 1'b1;
        r.ochar = cell_mem[dp_reg][7:0] & m[7:0];
      end
      OP_OPEN, OP_CLOSE: begin
        zero = (cell_mem[dp_reg] & m) == 0;
        if ((op == OP_OPEN) == zero) begin
          if (!partner_ok[pc_reg]) return ST_BRANCH;
          nxt = next_of(32'(partner[pc_reg]));
        end
      end
      default: ;
    endcase
    pc_reg = nxt;
    return (nxt < prog_len) ? ST_NORMAL : ST_EXIT;
  endfunction

  // apply one accepted transaction to the predicted state
  function automatic bf_res_t core_apply(input logic [1:0] req, input logic [7:0] pb,
                                         input logic [7:0] ib, input logic eof);
    bf_res_t r;
    r = '0;
    case (req)
      REQ_LOAD:  r.status = append_byte(pb);
      REQ_STEP:  r.status = run_instr(ib, eof, r);
      REQ_CLEAR: wipe_core();
      default: ;
    endcase
    r.pc = pc_reg[12:0];
    r.cidx = dp_reg[11:0];
    return r;
  endfunction

  // result check first, then record accepted transaction
  always @(posedge clk) begin
    bf_res_t e;
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction");
          fails++;
        end else begin
          e = expected_results.pop_front();
          if (out_status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_status); fails++;
          end
          if (out_out_valid !== e.ovalid) begin
            $error("out_valid exp %0d got %0d", e.ovalid, out_out_valid); fails++;
          end
          if (out_out_char !== e.ochar) begin
            $error("out_char exp %0h got %0h", e.ochar, out_out_char); fails++;
          end
          if (out_in_taken !== e.taken) begin
            $error("in_taken exp %0d got %0d", e.taken, out_in_taken); fails++;
          end
          if (out_pc_now !== e.pc) begin
            $error("pc_now exp %0d got %0d", e.pc, out_pc_now); fails++;
          end
          if (out_cell_index !== e.cidx) begin
            $error("cell_index exp %0d got %0d", e.cidx, out_cell_index); fails++;
          end
        end
      end
      if (start && !busy)
        expected_results.push_back(core_apply(in_req_type, in_program_byte,
                                              in_in_byte, in_in_eof));
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("[brainfuck_core] ERROR");
      $finish;
    end
  end

  // send one transaction; start stays high afterwards until the next gap or hold_off
  task automatic send_item(input logic [1:0] req, input logic [7:0] pb,
                           input logic [7:0] ib, input logic eof);
    @(negedge clk);
    if ($urandom_range(99) < gap_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start = 1'b1;
    in_req_type = req;
    in_program_byte = pb;
    in_in_byte = ib;
    in_in_eof = eof;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  // stop sending and wait for every expected result
  task automatic hold_off();
    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    hold_off();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = idx ? 3'd4 : 3'd0;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    if (idx == CFG_IDX_SIZE) width_code = val[1:0];
    else cells_used = 32'(val[12:0]);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic load_str(input string s);
    for (int i = 0; i < s.len(); i++) send_item(REQ_LOAD, s[i], 8'h00, 1'b0);
  endtask

  task automatic step_n(input int n);
    repeat (n) send_item(REQ_STEP, 8'($urandom), 8'($urandom), $urandom_range(9) == 0);
  endtask

  // every opcode, eof, unknown request, bracket errors, range errors
  task automatic test_directed();
    write_reg(CFG_IDX_SIZE, 32'(SIZE_8));
    write_reg(CFG_IDX_CELLS, 4096);
    load_str(",.[-]z<");
    send_item(REQ_STEP, 8'hff, 8'h81, 1'b0);
    send_item(REQ_STEP, 8'h00, 8'h00, 1'b0);
    step_n(4);
    send_item(REQ_STEP, 8'h00, 8'h00, 1'b1);
    send_item(REQ_NONE, 8'hff, 8'hff, 1'b1);
    send_item(REQ_CLEAR, 8'h00, 8'h00, 1'b0);
    load_str("+]-[>");
    step_n(3);
    write_reg(CFG_IDX_CELLS, 0);
    step_n(2);
    write_reg(CFG_IDX_CELLS, 8191);
    write_reg(CFG_IDX_SIZE, 32'(SIZE_64));
    load_str(">.");
    step_n(3);
  endtask

  function automatic logic [7:0] pick_byte(inout int depth);
    int k;
    k = $urandom_range(99);
    if (k < 8) return 8'($urandom);
    if (k < 16) begin
      depth++;
      return OP_OPEN;
    end
    if (k < 24 && (depth > 0 || k == 23)) begin
      if (depth > 0) depth--;
      return OP_CLOSE;
    end
    case ($urandom_range(5))
      0: return OP_INC;
      1: return OP_DEC;
      2: return OP_LEFT;
      3: return OP_RIGHT;
      4: return OP_IN;
      default: return OP_OUT;
    endcase
  endfunction

  // random programs under random widths and cell counts
  task automatic test_random_programs(input int n_items);
    int sent, depth;
    logic [12:0] cells;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) begin
        write_reg(CFG_IDX_SIZE, $urandom_range(3));
        case ($urandom_range(5))
          0: cells = 13'd0;
          1: cells = 13'd1;
          2: cells = 13'd8191;
          3: cells = 13'd4096;
          default: cells = 13'($urandom_range(2, 40));
        endcase
        write_reg(CFG_IDX_CELLS, 32'(cells));
      end
      if ($urandom_range(9) < 7) begin
        send_item(REQ_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom));
        sent++;
      end
      depth = 0;
      repeat ($urandom_range(3, 24)) begin
        send_item(REQ_LOAD, pick_byte(depth), 8'($urandom), 1'($urandom));
        sent++;
      end
      repeat (depth) if ($urandom_range(3) != 0) begin
        send_item(REQ_LOAD, OP_CLOSE, 8'($urandom), 1'($urandom));
        sent++;
      end
      repeat ($urandom_range(10, 50)) begin
        if ($urandom_range(49) == 0)
          send_item(REQ_NONE, 8'($urandom), 8'($urandom), 1'($urandom));
        else send_item(REQ_STEP, 8'($urandom), 8'($urandom), $urandom_range(7) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    fails = 0;
    cycles = 0;
    gap_pct = 7;
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = REQ_LOAD;
    in_program_byte = '0;
    in_in_byte = '0;
    in_in_eof = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    width_code = SIZE_8;
    cells_used = 4096;
    wipe_core();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    gap_pct = 7;
    test_random_programs(300);
    gap_pct = 71;
    test_random_programs(300);
    gap_pct = 0;
    test_random_programs(300);

    hold_off();
    if (fails == 0) $display("[brainfuck_core] OK");
    else $display("[brainfuck_core] ERROR");
    $finish;
  end

endmodule
